// ===== sv/cbts_pkg.sv =====
// types and constants shared by the can bit timing sync block
package cbts_pkg;

    // internal segment state, hard sync only exists within a tick
    typedef enum logic [1:0] {
        SEG_SYNC   = 2'd0,
        SEG_PHASE1 = 2'd1,
        SEG_PHASE2 = 2'd2,
        SEG_HARD   = 2'd3
    } seg_state_t;

    // segment codes as reported on the result word
    localparam logic [1:0] SEGMENT_SYNC   = 2'd0;
    localparam logic [1:0] SEGMENT_PHASE1 = 2'd1;
    localparam logic [1:0] SEGMENT_PHASE2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE1_LEN = 2'd0;
    localparam logic [1:0] REG_PHASE2_LEN = 2'd1;
    localparam logic [1:0] REG_JUMP_WIDTH = 2'd2;

    localparam logic [7:0] PHASE1_LEN_RST = 8'd6;
    localparam logic [7:0] PHASE2_LEN_RST = 8'd3;
    localparam logic [6:0] JUMP_WIDTH_RST = 7'd1;

    typedef struct packed {
        logic edge_seen;
        logic bus_idle;
    } in_word_t;

    typedef struct packed {
        logic [1:0] segment;
        logic       write_point;
        logic       sample_point;
    } out_word_t;

    typedef struct packed {
        logic [7:0] phase1_len;
        logic [7:0] phase2_len;
        logic [6:0] jump_width;
    } cfg_t;

endpackage

// ===== sv/cbts_core.sv =====
// segment state machine with counter, working phase lengths and resync logic
module cbts_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  cbts_pkg::in_word_t  item,
    input  cbts_pkg::cfg_t      cfg,
    output cbts_pkg::out_word_t result
);
    import cbts_pkg::*;

    seg_state_t seg_reg, seg_next, seg_eff;
    logic [9:0] count_reg, count_next;
    logic [8:0] wp1_reg, wp1_next;
    logic [7:0] wp2_reg, wp2_next;
    logic       pend_reg, pend_next, pend;

    logic [9:0] jw_ext;
    logic [9:0] corr1;
    logic [9:0] end_q;
    logic [9:0] end_gap;
    logic [9:0] corr2;
    logic [7:0] e2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= SEG_SYNC;
            count_reg <= '0;
            wp1_reg   <= '0;
            wp2_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else if (step)
        begin
            seg_reg   <= seg_next;
            count_reg <= count_next;
            wp1_reg   <= wp1_next;
            wp2_reg   <= wp2_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        jw_ext  = {3'b000, cfg.jump_width};
        corr1   = (jw_ext < count_reg) ? jw_ext : count_reg;
        end_q   = {1'b0, wp1_reg} + {2'b00, wp2_reg};
        end_gap = (count_reg > end_q) ? count_reg - end_q : end_q - count_reg;
        corr2   = (jw_ext < end_gap) ? jw_ext : end_gap;
        e2      = {1'b0, corr2[6:0]};

        // an edge with the bus idle forces hard sync
        seg_eff    = (item.edge_seen && item.bus_idle) ? SEG_HARD : seg_reg;
        pend       = pend_reg | item.edge_seen;
        seg_next   = seg_reg;
        count_next = count_reg + 10'd1;
        wp1_next   = wp1_reg;
        wp2_next   = wp2_reg;
        pend_next  = pend;
        result     = '0;

        unique case (seg_eff) inside
            SEG_SYNC, SEG_HARD:
            begin
                result.segment     = SEGMENT_SYNC;
                result.write_point = (seg_eff == SEG_SYNC);
                count_next         = 10'd1;
                wp1_next           = {1'b0, cfg.phase1_len};
                wp2_next           = cfg.phase2_len;
                pend_next          = 1'b0;
                seg_next           = SEG_PHASE1;
            end
            SEG_PHASE1:
            begin
                result.segment = SEGMENT_PHASE1;
                // lengthen only once per bit
                if (pend && (wp1_reg == {1'b0, cfg.phase1_len}))
                begin
                    pend_next = 1'b0;
                    wp1_next  = wp1_reg + {2'b00, corr1[6:0]};
                end
                if (count_reg == {1'b0, wp1_next})
                begin
                    result.sample_point = 1'b1;
                    seg_next            = SEG_PHASE2;
                end
            end
            default:
            begin
                result.segment = SEGMENT_PHASE2;
                // shorten only once per bit, floor at zero
                if (pend && (wp2_reg == cfg.phase2_len))
                begin
                    pend_next = 1'b0;
                    wp2_next  = (wp2_reg > e2) ? wp2_reg - e2 : 8'd0;
                end
                if (count_reg == ({1'b0, wp1_reg} + {2'b00, wp2_next}))
                    seg_next = SEG_SYNC;
            end
        endcase
    end

endmodule

// ===== sv/can_bit_timing_sync.sv =====
// top level of the can bit timing sync block: config registers, input and result registers
//
//  channel | signals                          | word
//  --------+----------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data      | edge_seen, bus_idle (one tick)
//  out     | out_valid, out_ready, out_data   | segment, write_point, sample_point
//  cfg     | cfg_we, cfg_index, cfg_data      | phase1_len, phase2_len, jump_width
//
// one word in and one word out per clock cycle sustained while out_ready is high;
// the timing state steps as a word moves from the input register into the
// result register; out_valid rises as the word is written into the result register.
// a stalled result register holds the input register; it still takes a new
// word in the cycle the result is taken.
// reset clears the segment state, counter and flags; config returns to 6, 3, 1.
module can_bit_timing_sync (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cbts_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cbts_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import cbts_pkg::*;

    cfg_t      cfg_reg;
    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;
    out_word_t result;
    logic      advance;
    logic      in_fire;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase1_len <= PHASE1_LEN_RST;
            cfg_reg.phase2_len <= PHASE2_LEN_RST;
            cfg_reg.jump_width <= JUMP_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE1_LEN: cfg_reg.phase1_len <= cfg_data;
                REG_PHASE2_LEN: cfg_reg.phase2_len <= cfg_data;
                REG_JUMP_WIDTH: cfg_reg.jump_width <= cfg_data[6:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    cbts_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// ===== sv/cbts_checker.sv =====
// port-level checks for the can bit timing sync block and their bind
module cbts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input cbts_pkg::out_word_t out_data
);
    import cbts_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_seg_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.segment == SEGMENT_SYNC ||
                       out_data.segment == SEGMENT_PHASE1 ||
                       out_data.segment == SEGMENT_PHASE2))
        else $error("segment code out of range");

    a_write_pt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_point |-> out_data.segment == SEGMENT_SYNC)
        else $error("write point outside sync segment");

    a_sample_pt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sample_point |-> out_data.segment == SEGMENT_PHASE1)
        else $error("sample point outside phase 1");

endmodule

bind can_bit_timing_sync cbts_checker u_cbts_checker (.*);
